/* rtl/core/eqt_pkg.sv */
package eqt_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int MAX_RESULTS   = 16;
	localparam int ID_W          = 4;
	localparam int TIME_W        = 64;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_ACTIVATE   = 2'd0;
	localparam logic [1:0] OP_DEACTIVATE = 2'd1;
	localparam logic [1:0] OP_TICK       = 2'd2;
	localparam logic [1:0] OP_QUERY      = 2'd3;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_NEXT    = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ID_W-1:0]   event_id;
		logic [TIME_W-1:0] expiry_time;
		logic [TIME_W-1:0] now_time;
	} eqt_in_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ID_W-1:0]   slot_id;
		logic              was_active;
		logic [TIME_W-1:0] remaining;
		logic              last;
	} eqt_out_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [TIME_W-1:0] expiry;
	} eqt_scan_res_t;

endpackage

/* rtl/core/event_timer_queue_unit.sv */
// Activate and deactivate: the result is registered in res_q, then in rsp_q once the output is free.
// Query: one scan of the expiry memory gives the result.
// Tick: one scan per expired slot, plus one closing scan, and an emit of each expired slot
// but the last between its scans.
// The scan reads the single read port of the expiry memory, one slot per cycle.
// One item is in work at a time; the next is taken once its last result is registered.
// Reset clears all active marks and the control state; the expiry memory keeps its contents.
module event_timer_queue_unit #(
	parameter int NUM_SLOTS = eqt_pkg::NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  eqt_pkg::eqt_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output eqt_pkg::eqt_out_t rsp
);

	import eqt_pkg::*;

	localparam int SLOT_W = $clog2(NUM_SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic [1:0]         op_q;
	logic [TIME_W-1:0]  now_q;
	logic [SLOT_W-1:0]  pend_q;
	logic               have_pend_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               scan_next_q;
	eqt_out_t           res_q;
	eqt_out_t           rsp_q;
	logic               rsp_valid_q;
	logic [NUM_SLOTS-1:0] active_q;

	logic               req_fire;
	logic               in_range;
	logic [SLOT_W-1:0]  req_idx;
	logic               was;
	logic               emit_fire;
	logic               due;
	logic [TIME_W-1:0]  rem;
	logic               scan_start;
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_raddr;
	logic [TIME_W-1:0]  ram_rdata;
	eqt_scan_res_t      scan_res;
	logic [SLOT_W-1:0]  best_idx;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign in_range  = (32'(req.event_id) < NUM_SLOTS);
	assign req_idx   = SLOT_W'(req.event_id);
	assign was       = in_range && active_q[req_idx];
	assign emit_fire = (state_q == ST_EMIT) && (!rsp_valid_q || rsp_ready);
	assign due       = scan_res.found && (scan_res.expiry <= now_q)
	                   && (cnt_q < CNT_W'(MAX_RESULTS));
	assign rem       = (scan_res.found && (scan_res.expiry > now_q))
	                   ? (scan_res.expiry - now_q) : '0;
	assign ram_we    = req_fire && (req.opcode == OP_ACTIVATE) && in_range;

	// A new scan starts for tick and query, after each removal, and after an emitted slot.
	assign scan_start = (req_fire && ((req.opcode == OP_TICK) || (req.opcode == OP_QUERY)))
	                    || ((state_q == ST_SCAN) && scan_res.done && (op_q == OP_TICK)
	                        && due && !have_pend_q)
	                    || (emit_fire && scan_next_q);

	eqt_ram #(
		.WIDTH(TIME_W),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(req_idx),
		.wdata(req.expiry_time),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	eqt_scan #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.active  (active_q),
		.raddr   (ram_raddr),
		.rdata   (ram_rdata),
		.res     (scan_res),
		.best_idx(best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ACTIVATE;
			now_q       <= '0;
			pend_q      <= '0;
			have_pend_q <= 1'b0;
			cnt_q       <= '0;
			scan_next_q <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			active_q    <= '0;
		end else begin
			if (emit_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						op_q        <= req.opcode;
						now_q       <= req.now_time;
						have_pend_q <= 1'b0;
						cnt_q       <= '0;
						scan_next_q <= 1'b0;
						if ((req.opcode == OP_ACTIVATE) || (req.opcode == OP_DEACTIVATE)) begin
							if (in_range) begin
								active_q[req_idx] <= (req.opcode == OP_ACTIVATE);
							end
							res_q <= '{kind: KIND_ACK, slot_id: req.event_id, was_active: was,
							           remaining: '0, last: 1'b1};
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						if (op_q == OP_QUERY) begin
							res_q <= '{kind: KIND_NEXT, slot_id: '0, was_active: 1'b0,
							           remaining: rem, last: 1'b1};
							scan_next_q <= 1'b0;
							state_q     <= ST_EMIT;
						end else if (due) begin
							// The slot found now is held back until the next scan tells
							// whether it is the last one of this tick.
							active_q[best_idx] <= 1'b0;
							pend_q             <= best_idx;
							have_pend_q        <= 1'b1;
							cnt_q              <= cnt_q + 1'b1;
							if (have_pend_q) begin
								res_q <= '{kind: KIND_EXPIRED, slot_id: ID_W'(pend_q),
								           was_active: 1'b0, remaining: '0, last: 1'b0};
								scan_next_q <= 1'b1;
								state_q     <= ST_EMIT;
							end
						end else begin
							if (have_pend_q) begin
								res_q <= '{kind: KIND_EXPIRED, slot_id: ID_W'(pend_q),
								           was_active: 1'b0, remaining: '0, last: 1'b1};
							end else begin
								res_q <= '{kind: KIND_NONE, slot_id: '0, was_active: 1'b0,
								           remaining: '0, last: 1'b1};
							end
							scan_next_q <= 1'b0;
							state_q     <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						rsp_q   <= res_q;
						state_q <= scan_next_q ? ST_SCAN : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/core/eqt_ram.sv */
module eqt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/eqt_scan.sv */
module eqt_scan #(
	parameter int NUM_SLOTS = eqt_pkg::NUM_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_SLOTS-1:0]         active,
	output logic [$clog2(NUM_SLOTS)-1:0] raddr,
	input  logic [eqt_pkg::TIME_W-1:0]   rdata,
	output eqt_pkg::eqt_scan_res_t       res,
	output logic [$clog2(NUM_SLOTS)-1:0] best_idx
);

	import eqt_pkg::*;

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

	logic              busy_q;
	logic [SLOT_W-1:0] cnt_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	logic              found_q;
	logic              done_q;
	logic [TIME_W-1:0] best_exp_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic              take;

	assign raddr = cnt_q;

	// Slots arrive in ascending order, so a strict compare keeps the lower index on ties.
	assign take = rd_vld_s1 && active[rd_idx_s1] && (!found_q || (rdata < best_exp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			found_q    <= 1'b0;
			done_q     <= 1'b0;
			best_exp_q <= '0;
			best_idx_q <= '0;
		end else begin
			rd_vld_s1 <= busy_q;
			rd_idx_s1 <= cnt_q;
			done_q    <= rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (busy_q) begin
					if (cnt_q == LAST_IDX) begin
						busy_q <= 1'b0;
						cnt_q  <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				if (take) begin
					found_q    <= 1'b1;
					best_exp_q <= rdata;
					best_idx_q <= rd_idx_s1;
				end
			end
		end
	end

	assign res.done   = done_q;
	assign res.found  = found_q;
	assign res.expiry = best_exp_q;
	assign best_idx   = best_idx_q;

endmodule

/* rtl/core/eqt_checker.sv */
module eqt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input eqt_pkg::eqt_in_t  req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input eqt_pkg::eqt_out_t rsp
);

	import eqt_pkg::*;

	// A stalled response transaction holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Only one request is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// Every response other than an expired slot ends its request.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind != KIND_EXPIRED) |-> rsp.last)
		else $error("single response without last");

	// Only the query response carries a remaining time.
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind != KIND_NEXT) |-> (rsp.remaining == '0))
		else $error("remaining set outside query");

	// Expired and nothing-due responses never report a prior active mark.
	a_was_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.kind == KIND_EXPIRED) || (rsp.kind == KIND_NONE))
		|-> !rsp.was_active)
		else $error("was_active set on tick response");

endmodule

bind event_timer_queue_unit eqt_checker u_eqt_checker (.*);
